@@ src/aft_pkg.sv @@
`timescale 1ns / 1ps
// Package for the animation frame timer: table sizing constants,
// item kinds, sequencer states and channel payload types. No dependencies.
package aft_pkg;

  localparam int MAX_FRAMES    = 256;
  localparam int FRAME_W       = $clog2(MAX_FRAMES);
  localparam int COUNT_W       = $clog2(MAX_FRAMES + 1);
  localparam int TIME_W        = 32;
  localparam int SKIP_W        = 6;
  localparam int FRAME_IDX_W   = 8;
  localparam logic [SKIP_W-1:0] MAX_SKIP_RST = SKIP_W'(10);

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_PLAY   = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_PUSH
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [TIME_W-1:0] frame_delay;
    logic [TIME_W-1:0] time_now;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   advanced;
    logic                   playing;
    logic                   overflow;
  } out_item_t;

endpackage

@@ src/animation_frame_timer_top.sv @@
`timescale 1ns / 1ps
// Animation frame timer: delay table memory and tick sequencer.
// Depends on aft_pkg.
//
// Usage: each input beat (in_valid/in_ready, in_data) carries one command:
// append a frame delay, play, stop or a time tick. Every input beat gives
// exactly one output beat (out_valid/out_ready, out_data) with the current
// frame, the advanced flag, the playing flag and the overflow flag.
// cfg_valid/cfg_ready/cfg_data writes max_skip; cfg_ready is always high.
// One item is processed at a time. A running tick advances the frame
// while the accumulator reaches the current delay, at most max_skip+1
// times, each advance being one read, compare and subtract on the delay
// table, a memory with registered read data.
// The output beat sits in its own register, so the next input is accepted
// while it waits; the following result is held until out_ready frees the
// register. Reset clears frame count, frame index, accumulator, time base
// and playing, and sets max_skip to 10; the table contents stay undefined
// and are only used below the frame count.
module animation_frame_timer_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  aft_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output aft_pkg::out_item_t       out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [aft_pkg::SKIP_W-1:0] cfg_data
);
  import aft_pkg::*;

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [FRAME_W-1:0] cur_r, cur_nxt;
  logic [TIME_W-1:0]  acc_r, acc_nxt;
  logic [TIME_W-1:0]  last_r, last_nxt;
  logic               running_r, running_nxt;
  logic [SKIP_W-1:0]  max_skip_r;
  logic [SKIP_W-1:0]  moves_r, moves_nxt;
  logic               adv_r, adv_nxt;
  logic               ovf_r, ovf_nxt;

  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [TIME_W-1:0]  mem [MAX_FRAMES];
  logic [TIME_W-1:0]  rdata_r;
  logic [FRAME_W-1:0] rd_addr;
  logic               wr_en;

  logic               in_fire;
  logic               out_free;
  logic               hit;
  logic               table_full;
  logic [COUNT_W-1:0] cur_inc;
  logic [FRAME_W-1:0] cur_wrap;

  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign hit        = acc_r >= rdata_r;
  assign table_full = count_r == COUNT_W'(MAX_FRAMES);
  assign cur_inc    = COUNT_W'({1'b0, cur_r}) + COUNT_W'(1);
  assign cur_wrap   = (cur_inc >= count_r) ? '0 : cur_inc[FRAME_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.kind == KIND_TICK && running_r) begin
            state_nxt = ST_CMP;
          end else begin
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_CMP: begin
        if (!hit || moves_r == max_skip_r) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and control
  always_comb begin
    in_ready = state_r == ST_IDLE;
    wr_en    = (state_r == ST_IDLE) && in_fire && in_data.kind == KIND_APPEND && !table_full;
    rd_addr  = cur_r;
    if (state_r == ST_CMP && hit) begin
      rd_addr = cur_wrap;
    end
  end

  // datapath
  always_comb begin
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    acc_nxt     = acc_r;
    last_nxt    = last_r;
    running_nxt = running_r;
    moves_nxt   = moves_r;
    adv_nxt     = adv_r;
    ovf_nxt     = ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          adv_nxt   = 1'b0;
          ovf_nxt   = 1'b0;
          moves_nxt = '0;
          case (in_data.kind)
            KIND_APPEND: begin
              if (table_full) begin
                ovf_nxt = 1'b1;
              end else begin
                count_nxt = count_r + COUNT_W'(1);
              end
            end
            KIND_PLAY: begin
              if (count_r != '0) begin
                acc_nxt     = '0;
                last_nxt    = in_data.time_now;
                cur_nxt     = '0;
                running_nxt = 1'b1;
              end
            end
            KIND_STOP: begin
              running_nxt = 1'b0;
            end
            KIND_TICK: begin
              if (running_r) begin
                acc_nxt  = acc_r + (in_data.time_now - last_r);
                last_nxt = in_data.time_now;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CMP: begin
        if (hit) begin
          adv_nxt = 1'b1;
          cur_nxt = cur_wrap;
          if (moves_r == max_skip_r) begin
            acc_nxt = '0;
          end else begin
            acc_nxt   = acc_r - rdata_r;
            moves_nxt = moves_r + SKIP_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      acc_r       <= '0;
      last_r      <= '0;
      running_r   <= 1'b0;
      moves_r     <= '0;
      adv_r       <= 1'b0;
      ovf_r       <= 1'b0;
      max_skip_r  <= MAX_SKIP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cur_r     <= cur_nxt;
      acc_r     <= acc_nxt;
      last_r    <= last_nxt;
      running_r <= running_nxt;
      moves_r   <= moves_nxt;
      adv_r     <= adv_nxt;
      ovf_r     <= ovf_nxt;
      if (cfg_valid && cfg_ready) begin
        max_skip_r <= cfg_data;
      end
      if (state_r == ST_PUSH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PUSH && out_free) begin
      out_data_r.frame_index <= FRAME_IDX_W'(cur_r);
      out_data_r.advanced    <= adv_r;
      out_data_r.playing     <= running_r;
      out_data_r.overflow    <= ovf_r;
    end
  end

  // delay table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[FRAME_W-1:0]] <= in_data.frame_delay;
    end
    rdata_r <= mem[rd_addr];
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cmp_running: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> running_r)
    else $error("advance loop without playback");

  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> COUNT_W'({1'b0, cur_r}) < count_r)
    else $error("frame index beyond frame count");

  a_moves_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> moves_r <= max_skip_r)
    else $error("advance count beyond max_skip");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("item accepted without processing");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for animation_frame_timer_top: directed command table, then random
// phases with bursty input beats, output stalls and max_skip changes between phases.
// Depends on aft_pkg and animation_frame_timer_top.
module testbench;
  import aft_pkg::*;

  localparam int N_DIR       = 21;
  localparam int PHASE_ITEMS = 240;
  localparam int FILL_ITEMS  = 400;

  localparam out_item_t O_IDLE  = '{frame_index: 8'd0, advanced: 1'b0, playing: 1'b0,
                                    overflow: 1'b0};
  localparam out_item_t O_PLAY0 = '{frame_index: 8'd0, advanced: 1'b0, playing: 1'b1,
                                    overflow: 1'b0};

  typedef struct packed {
    kind_t             kind;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] stamp;
    logic              typed;
    out_item_t         want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{KIND_TICK,   32'hFFFF_FFFF, 32'h1234_5678, 1'b1, O_IDLE},
    '{KIND_PLAY,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, O_IDLE},
    '{KIND_STOP,   32'h0000_0000, 32'h0000_0000, 1'b1, O_IDLE},
    '{KIND_APPEND, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, O_IDLE},
    '{KIND_PLAY,   32'h0000_0000, 32'd100,       1'b1, O_PLAY0},
    '{KIND_TICK,   32'h0000_0000, 32'd100,       1'b0, O_IDLE},
    '{KIND_APPEND, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, O_PLAY0},
    '{KIND_APPEND, 32'd3,         32'h0000_0000, 1'b1, O_PLAY0},
    '{KIND_TICK,   32'h0000_0000, 32'd101,       1'b0, O_IDLE},
    '{KIND_TICK,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0, O_IDLE},
    '{KIND_TICK,   32'h0000_0000, 32'd200,       1'b0, O_IDLE},
    '{KIND_TICK,   32'h0000_0000, 32'h7FFF_FFFF, 1'b0, O_IDLE},
    '{KIND_STOP,   32'h0000_0000, 32'h0000_0000, 1'b0, O_IDLE},
    '{KIND_TICK,   32'h0000_0000, 32'h8000_0000, 1'b0, O_IDLE},
    '{KIND_PLAY,   32'h0000_0000, 32'h0000_0000, 1'b1, O_PLAY0},
    '{KIND_PLAY,   32'h0000_0000, 32'hFFFF_FFF0, 1'b1, O_PLAY0},
    '{KIND_TICK,   32'h0000_0000, 32'hFFFF_FFF0, 1'b0, O_IDLE},
    '{KIND_TICK,   32'h0000_0000, 32'h0000_000F, 1'b0, O_IDLE},
    '{KIND_APPEND, 32'd1,         32'h0000_0000, 1'b0, O_IDLE},
    '{KIND_TICK,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0, O_IDLE},
    '{KIND_STOP,   32'h0000_0000, 32'h0000_0000, 1'b0, O_IDLE}
  };

  localparam logic [SKIP_W-1:0] SKIP_PLAN [6] = '{6'd0, 6'd63, 6'd1, 6'd0, 6'd63, 6'd0};

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SKIP_W-1:0] cfg_data;

  // frame sequencer state as the block should hold it
  logic [TIME_W-1:0]  delay_mem [MAX_FRAMES];
  logic [COUNT_W-1:0] n_frames;
  logic [FRAME_W-1:0] cur_frame;
  logic [TIME_W-1:0]  accum;
  logic [TIME_W-1:0]  time_base;
  logic               run;
  logic [SKIP_W-1:0]  skip_limit;

  out_item_t         pending_frames [$];
  logic [TIME_W-1:0] clock_now = '0;
  int                hold_cycles = 0;
  int                mismatch_count = 0;

  animation_frame_timer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
    if (mismatch_count < 40) begin
      $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got_v, want_v);
    end
    mismatch_count++;
  endtask

  function automatic out_item_t step_animation(in_item_t cmd);
    out_item_t res;
    int        moves;
    logic      done;
    res = '0;
    case (cmd.kind)
      KIND_APPEND: begin
        if (n_frames < MAX_FRAMES) begin
          delay_mem[n_frames[FRAME_W-1:0]] = cmd.frame_delay;
          n_frames = n_frames + 1'b1;
        end else begin
          res.overflow = 1'b1;
        end
      end
      KIND_PLAY: begin
        if (n_frames != 0) begin
          accum     = '0;
          time_base = cmd.time_now;
          cur_frame = '0;
          run       = 1'b1;
        end
      end
      KIND_STOP: run = 1'b0;
      KIND_TICK: begin
        if (run) begin
          accum     = accum + (cmd.time_now - time_base);
          time_base = cmd.time_now;
          if (accum >= delay_mem[cur_frame]) begin
            res.advanced = 1'b1;
            moves = 0;
            done  = 1'b0;
            while (!done) begin
              accum = accum - delay_mem[cur_frame];
              if (COUNT_W'(cur_frame) + 1'b1 >= n_frames) cur_frame = '0;
              else cur_frame = cur_frame + 1'b1;
              if (moves == int'(skip_limit)) begin
                accum = '0;
                done  = 1'b1;
              end else begin
                moves++;
                done = (accum < delay_mem[cur_frame]);
              end
            end
          end
        end
      end
      default: ;
    endcase
    res.frame_index = cur_frame;
    res.playing     = run;
    return res;
  endfunction

  // mostly ticks on a running time base; fill mode mostly appends, to drive the table toward overflow
  function automatic in_item_t make_cmd(bit fill);
    in_item_t cmd;
    int       pick;
    int       sel;
    cmd.kind        = KIND_TICK;
    cmd.frame_delay = $urandom;
    cmd.time_now    = $urandom;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    if (fill) pick = (pick < 60) ? 0 : (pick < 63) ? 6 : 99;
    if (pick < 5) begin
      cmd.kind = KIND_APPEND;
      if (sel < 55) cmd.frame_delay = $urandom_range(1, 20);
      else if (sel < 72) cmd.frame_delay = '0;
      else if (sel < 90) cmd.frame_delay = $urandom_range(21, 500);
      else if (sel < 97) cmd.frame_delay = $urandom;
      else cmd.frame_delay = '1;
    end else if (pick < 9) begin
      cmd.kind     = KIND_PLAY;
      cmd.time_now = clock_now;
    end else if (pick < 12) begin
      cmd.kind = KIND_STOP;
    end else if (pick < 14) begin
      cmd.kind = kind_t'($urandom_range(0, 3));
    end else begin
      if (sel < 65) clock_now = clock_now + $urandom_range(0, 60);
      else if (sel < 85) clock_now = clock_now + $urandom_range(61, 3000);
      else if (sel < 93) clock_now = clock_now;
      else clock_now = clock_now + $urandom;
      cmd.time_now = clock_now;
    end
    return cmd;
  endfunction

  // called at a rising edge; valid stays high on return
  task automatic send_cmd(input in_item_t cmd, input logic typed, input out_item_t typed_want);
    out_item_t predicted;
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    predicted = step_animation(cmd);
    pending_frames.push_back(typed ? typed_want : predicted);
  endtask

  task automatic write_max_skip(input logic [SKIP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    skip_limit = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    for (int k = 0; k < 20000 && pending_frames.size() != 0; k++) @(posedge clk);
  endtask

  task automatic run_phase(input int n_items, input bit fill);
    int sent;
    int burst;
    int gap;
    bit steady;
    sent   = 0;
    steady = ($urandom_range(0, 3) == 0);
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        send_cmd(make_cmd(fill), 1'b0, O_IDLE);
        sent++;
      end
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("result beat with nothing pending", out_data, 0);
      end else begin
        want = pending_frames.pop_front();
        if (out_data.frame_index !== want.frame_index)
          report_mismatch("frame_index", out_data.frame_index, want.frame_index);
        if (out_data.advanced !== want.advanced)
          report_mismatch("advanced", out_data.advanced, want.advanced);
        if (out_data.playing !== want.playing)
          report_mismatch("playing", out_data.playing, want.playing);
        if (out_data.overflow !== want.overflow)
          report_mismatch("overflow", out_data.overflow, want.overflow);
      end
    end
  end

  initial begin : receiver
    int          left;
    int          mode;
    logic [15:0] stall_bits;
    out_ready  = 1'b0;
    left       = 0;
    mode       = 0;
    stall_bits = '1;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode       = $urandom_range(0, 2);
          stall_bits = 16'($urandom) | 16'h0101;
          left       = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= stall_bits[left % 16];
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    in_item_t cmd;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    rst_n      = 1'b0;
    n_frames   = '0;
    cur_frame  = '0;
    accum      = '0;
    time_base  = '0;
    run        = 1'b0;
    skip_limit = MAX_SKIP_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      cmd.kind        = DIR_ROWS[r].kind;
      cmd.frame_delay = DIR_ROWS[r].delay;
      cmd.time_now    = DIR_ROWS[r].stamp;
      send_cmd(cmd, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      write_max_skip((ph == 3) ? SKIP_W'($urandom) : SKIP_PLAN[ph]);
      // long output stall while input keeps coming
      if (ph == 1) hold_cycles = 400;
      run_phase(PHASE_ITEMS, 1'b0);
    end

    drain_results();
    write_max_skip('1);
    run_phase(FILL_ITEMS, 1'b1);

    drain_results();
    repeat (80) @(posedge clk);
    if (pending_frames.size() != 0)
      report_mismatch("results never arrived", pending_frames.size(), 0);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
